### hw/rtl/ptz_status_frame_parser_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the pan/tilt status datagram parser
// Clocked, reset-qualified property wrappers used by the checker.
// ----------------------------------------------------------------------------
`ifndef PTZ_STATUS_FRAME_PARSER_MACROS_SVH
`define PTZ_STATUS_FRAME_PARSER_MACROS_SVH

// Same-cycle implication.
`define PTZSFP_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PTZSFP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/ptzsfp_pkg.sv
// ----------------------------------------------------------------------------
// ptzsfp_pkg
// Types and constants shared by the status datagram parser.
// ----------------------------------------------------------------------------
package ptzsfp_pkg;

    // Header bytes and frame length
    localparam logic [7:0] HDR0      = 8'hEB;
    localparam logic [7:0] HDR1      = 8'h90;
    localparam logic [7:0] HDR2      = 8'h01;
    localparam logic [3:0] FRAME_LEN = 4'd14;
    localparam logic [3:0] COUNT_SAT = 4'd15;

    // Byte positions within the datagram
    localparam logic [3:0] IDX_HDR0      = 4'd0;
    localparam logic [3:0] IDX_HDR1      = 4'd1;
    localparam logic [3:0] IDX_HDR2      = 4'd2;
    localparam logic [3:0] IDX_SERVO     = 4'd3;
    localparam logic [3:0] IDX_PAN_HI    = 4'd4;
    localparam logic [3:0] IDX_PAN_LO    = 4'd5;
    localparam logic [3:0] IDX_TILT_HI   = 4'd6;
    localparam logic [3:0] IDX_TILT_LO   = 4'd7;
    localparam logic [3:0] IDX_PRATE_HI  = 4'd8;
    localparam logic [3:0] IDX_PRATE_LO  = 4'd9;
    localparam logic [3:0] IDX_TRATE_HI  = 4'd10;
    localparam logic [3:0] IDX_TRATE_LO  = 4'd11;
    localparam logic [3:0] IDX_SUM_FIRST = 4'd2;
    localparam logic [3:0] IDX_SUM_LAST  = 4'd12;
    localparam logic [3:0] IDX_CHECK     = 4'd13;

    // Angle limits, hundredths of a degree
    localparam logic [15:0]        PAN_FULL_TURN = 16'd36000;
    localparam logic signed [15:0] TILT_MAX      = 16'sd9000;
    localparam logic signed [15:0] TILT_MIN      = -16'sd9000;

    // Frame status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_LEN  = 2'd1;
    localparam logic [1:0] ST_BAD_HDR  = 2'd2;
    localparam logic [1:0] ST_BAD_CSUM = 2'd3;

    typedef struct packed {
        logic [3:0]  count;
        logic [7:0]  sum;
        logic        hdr_good;
        logic        sum_ok;
        logic [7:0]  servo;
        logic [15:0] pan;
        logic [15:0] tilt;
        logic [15:0] prate;
        logic [15:0] trate;
    } t_frame_state;

    localparam t_frame_state FRAME_STATE_RST = '{
        count:    4'd0,
        sum:      8'd0,
        hdr_good: 1'b1,
        sum_ok:   1'b0,
        servo:    8'd0,
        pan:      16'd0,
        tilt:     16'd0,
        prate:    16'd0,
        trate:    16'd0
    };

endpackage

### hw/rtl/ptzsfp_in_if.sv
// ----------------------------------------------------------------------------
// ptzsfp_in_if
// Byte stream channel: one datagram byte and an end flag per transaction.
// ----------------------------------------------------------------------------
interface ptzsfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_datagram;

    modport source (output valid, output data_byte, output end_of_datagram, input ready);
    modport sink   (input valid, input data_byte, input end_of_datagram, output ready);
endinterface

### hw/rtl/ptzsfp_out_if.sv
// ----------------------------------------------------------------------------
// ptzsfp_out_if
// Parsed status channel: one decoded datagram per transaction.
// ----------------------------------------------------------------------------
interface ptzsfp_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         frame_status;
    logic [7:0]         servo_state;
    logic [15:0]        pan_angle;
    logic signed [14:0] tilt_angle;
    logic signed [15:0] pan_rate;
    logic signed [15:0] tilt_rate;

    modport source (
        output valid, output frame_status, output servo_state, output pan_angle,
        output tilt_angle, output pan_rate, output tilt_rate, input ready
    );
    modport sink (
        input valid, input frame_status, input servo_state, input pan_angle,
        input tilt_angle, input pan_rate, input tilt_rate, output ready
    );
endinterface

### hw/rtl/ptzsfp_accum.sv
// ----------------------------------------------------------------------------
// ptzsfp_accum
// Per-byte datagram state: byte count, header check, checksum, field capture.
// ----------------------------------------------------------------------------
module ptzsfp_accum (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_step,
    input  logic                    i_last,
    input  logic [7:0]              i_byte,
    output ptzsfp_pkg::t_frame_state o_final
);

    ptzsfp_pkg::t_frame_state r_state;
    ptzsfp_pkg::t_frame_state n_state;

    always_comb begin
        n_state = r_state;
        if ((r_state.count == ptzsfp_pkg::IDX_HDR0 && i_byte != ptzsfp_pkg::HDR0) ||
            (r_state.count == ptzsfp_pkg::IDX_HDR1 && i_byte != ptzsfp_pkg::HDR1) ||
            (r_state.count == ptzsfp_pkg::IDX_HDR2 && i_byte != ptzsfp_pkg::HDR2)) begin
            n_state.hdr_good = 1'b0;
        end
        if (r_state.count >= ptzsfp_pkg::IDX_SUM_FIRST &&
            r_state.count <= ptzsfp_pkg::IDX_SUM_LAST) begin
            n_state.sum = r_state.sum + i_byte;
        end
        if (r_state.count == ptzsfp_pkg::IDX_CHECK) begin
            n_state.sum_ok = (i_byte == r_state.sum);
        end
        case (r_state.count)
            ptzsfp_pkg::IDX_SERVO:    n_state.servo       = i_byte;
            ptzsfp_pkg::IDX_PAN_HI:   n_state.pan[15:8]   = i_byte;
            ptzsfp_pkg::IDX_PAN_LO:   n_state.pan[7:0]    = i_byte;
            ptzsfp_pkg::IDX_TILT_HI:  n_state.tilt[15:8]  = i_byte;
            ptzsfp_pkg::IDX_TILT_LO:  n_state.tilt[7:0]   = i_byte;
            ptzsfp_pkg::IDX_PRATE_HI: n_state.prate[15:8] = i_byte;
            ptzsfp_pkg::IDX_PRATE_LO: n_state.prate[7:0]  = i_byte;
            ptzsfp_pkg::IDX_TRATE_HI: n_state.trate[15:8] = i_byte;
            ptzsfp_pkg::IDX_TRATE_LO: n_state.trate[7:0]  = i_byte;
            default: ;
        endcase
        if (r_state.count != ptzsfp_pkg::COUNT_SAT) begin
            n_state.count = r_state.count + 4'd1;
        end
    end

    // Final byte hands its updated state to the result stage and rearms.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ptzsfp_pkg::FRAME_STATE_RST;
        end else if (i_step) begin
            r_state <= i_last ? ptzsfp_pkg::FRAME_STATE_RST : n_state;
        end
    end

    assign o_final = n_state;

endmodule

### hw/rtl/ptzsfp_result.sv
// ----------------------------------------------------------------------------
// ptzsfp_result
// Status decode, angle wrap/clamp, and the output register.
// ----------------------------------------------------------------------------
module ptzsfp_result (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_load,
    input  ptzsfp_pkg::t_frame_state i_final,
    output logic                     o_stall,
    ptzsfp_out_if.source             o_out
);

    logic               r_vld;
    logic               n_vld;
    logic [1:0]         r_status;
    logic [7:0]         r_servo;
    logic [15:0]        r_pan;
    logic [14:0]        r_tilt;
    logic [15:0]        r_prate;
    logic [15:0]        r_trate;

    logic [1:0]         n_status;
    logic [15:0]        n_pan;
    logic signed [15:0] tilt_s;
    logic signed [15:0] tilt_clamped;
    logic               ok;

    always_comb begin
        if (i_final.count != ptzsfp_pkg::FRAME_LEN) begin
            n_status = ptzsfp_pkg::ST_BAD_LEN;
        end else if (!i_final.hdr_good) begin
            n_status = ptzsfp_pkg::ST_BAD_HDR;
        end else if (!i_final.sum_ok) begin
            n_status = ptzsfp_pkg::ST_BAD_CSUM;
        end else begin
            n_status = ptzsfp_pkg::ST_OK;
        end
        ok = (n_status == ptzsfp_pkg::ST_OK);

        // Negative pan wraps by one full turn; modulo 2^16 lands in 0..35999.
        n_pan = i_final.pan[15] ? (i_final.pan + ptzsfp_pkg::PAN_FULL_TURN) : i_final.pan;

        tilt_s = $signed(i_final.tilt);
        if (tilt_s > ptzsfp_pkg::TILT_MAX) begin
            tilt_clamped = ptzsfp_pkg::TILT_MAX;
        end else if (tilt_s < ptzsfp_pkg::TILT_MIN) begin
            tilt_clamped = ptzsfp_pkg::TILT_MIN;
        end else begin
            tilt_clamped = tilt_s;
        end
    end

    assign o_stall = r_vld && !o_out.ready;
    assign n_vld   = i_load || (r_vld && !o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_status <= n_status;
            r_servo  <= ok ? i_final.servo : 8'd0;
            r_pan    <= ok ? n_pan : 16'd0;
            r_tilt   <= ok ? tilt_clamped[14:0] : 15'd0;
            r_prate  <= ok ? i_final.prate : 16'd0;
            r_trate  <= ok ? i_final.trate : 16'd0;
        end
    end

    assign o_out.valid        = r_vld;
    assign o_out.frame_status = r_status;
    assign o_out.servo_state  = r_servo;
    assign o_out.pan_angle    = r_pan;
    assign o_out.tilt_angle   = $signed(r_tilt);
    assign o_out.pan_rate     = $signed(r_prate);
    assign o_out.tilt_rate    = $signed(r_trate);

endmodule

### hw/rtl/ptz_status_frame_parser.sv
// The final byte's transaction passes through the input register, then the result register,
// on its way to the status transaction. Throughput: one byte per cycle while input ready is high.
// Input ready drops only while a final byte waits in the input register behind a
// full result register that is not being drained; non-final bytes always flow.
// Reset: i_rst_n synchronous, active low; clears input/output valids and
// rearms the datagram state (count 0, header good, sum 0).
// ----------------------------------------------------------------------------
// ptz_status_frame_parser
// Pan/tilt status datagram parser. Bytes come in one per transaction with an
// end flag on the last; each datagram yields one status transaction.
// ----------------------------------------------------------------------------
module ptz_status_frame_parser (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ptzsfp_in_if.sink    i_in,
    ptzsfp_out_if.source o_out
);

    // Input register: one byte in flight ahead of the state update.
    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    logic       adv;        // input register may advance this cycle
    logic       step;       // registered byte is applied to datagram state
    logic       load;       // result register captures a finished datagram
    logic       res_stall;  // result register full and not being drained

    ptzsfp_pkg::t_frame_state final_state;

    // A non-final byte never touches the result register, so it may move
    // even while a result waits. A final byte needs room in the result stage.
    assign adv        = !r_in_vld || !r_in_last || !res_stall;
    assign step       = r_in_vld && adv;
    assign load       = step && r_in_last;
    assign i_in.ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (adv) begin
            r_in_vld <= i_in.valid;
        end
    end

    // Payload needs no reset; it is only consumed behind r_in_vld.
    always_ff @(posedge i_clk) begin
        if (adv && i_in.valid) begin
            r_in_byte <= i_in.data_byte;
            r_in_last <= i_in.end_of_datagram;
        end
    end

    // Byte counter, header check, checksum and field capture.
    ptzsfp_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_last  (r_in_last),
        .i_byte  (r_in_byte),
        .o_final (final_state)
    );

    // Status priority, angle conditioning and the output register.
    ptzsfp_result u_result (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_final (final_state),
        .o_stall (res_stall),
        .o_out   (o_out)
    );

endmodule

### hw/rtl/ptzsfp_checker.sv
// ----------------------------------------------------------------------------
// ptzsfp_checker
// Port-level checks on the parser's result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "ptz_status_frame_parser_macros.svh"

module ptzsfp_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [1:0]         i_frame_status,
    input logic [7:0]         i_servo_state,
    input logic [15:0]        i_pan_angle,
    input logic signed [14:0] i_tilt_angle,
    input logic signed [15:0] i_pan_rate,
    input logic signed [15:0] i_tilt_rate
);

    logic fields_zero;
    logic angles_in_range;

    assign fields_zero = (i_servo_state == 8'd0) && (i_pan_angle == 16'd0) &&
                         (i_tilt_angle == 15'sd0) && (i_pan_rate == 16'sd0) &&
                         (i_tilt_rate == 16'sd0);
    assign angles_in_range = (i_pan_angle < ptzsfp_pkg::PAN_FULL_TURN) &&
                             (i_tilt_angle <= 15'sd9000) && (i_tilt_angle >= -15'sd9000);

    `PTZSFP_ASSERT_NEXT(a_valid_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "result valid dropped while stalled")

    `PTZSFP_ASSERT_NEXT(a_payload_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_frame_status) && $stable(i_servo_state) && $stable(i_pan_angle) && $stable(i_tilt_angle) && $stable(i_pan_rate) && $stable(i_tilt_rate), "result payload changed while stalled")

    `PTZSFP_ASSERT_NOW(a_fail_zeroes, i_clk, i_rst_n, i_out_valid && (i_frame_status != ptzsfp_pkg::ST_OK), fields_zero, "failed datagram carries nonzero fields")

    `PTZSFP_ASSERT_NOW(a_ok_ranges, i_clk, i_rst_n, i_out_valid && (i_frame_status == ptzsfp_pkg::ST_OK), angles_in_range, "pan or tilt angle out of range")

endmodule

bind ptz_status_frame_parser ptzsfp_checker u_ptzsfp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_frame_status (o_out.frame_status),
    .i_servo_state  (o_out.servo_state),
    .i_pan_angle    (o_out.pan_angle),
    .i_tilt_angle   (o_out.tilt_angle),
    .i_pan_rate     (o_out.pan_rate),
    .i_tilt_rate    (o_out.tilt_rate)
);
